### rtl/aac_pkg.sv
// ----------------------------------------------------------------------------
// Annealing acceptance controller package
// Item types, outcome and register codes, sequencer states and the
// exp(-x) constant table used by the acceptance controller.
// ----------------------------------------------------------------------------
package aac_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_TEMPERATURE = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COOL_MULT           = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ITERATION_LIMIT     = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_STALL_LIMIT         = 8'd3;

  // Register reset values
  localparam logic [31:0] INITIAL_TEMPERATURE_RST = 32'd4529848;  // 0.27 in Q8.24
  localparam logic [15:0] COOL_MULT_RST           = 16'd62259;
  localparam logic [31:0] ITERATION_LIMIT_RST     = 32'd1000;
  localparam logic [31:0] STALL_LIMIT_RST         = 32'd100;

  // Quotient x is Q4.16; each shared-unit pass handles one quotient bit
  localparam int unsigned X_W       = 20;
  localparam logic [4:0]  STEP_LAST = 5'(X_W - 1);

  // Input command codes
  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_EVALUATE = 1'b1;

  typedef enum logic [2:0] {
    OUT_LOADED         = 3'd0,
    OUT_IMPROVED       = 3'd1,
    OUT_WORSE_ACCEPTED = 3'd2,
    OUT_WORSE_REJECTED = 3'd3,
    OUT_IGNORED        = 3'd4
  } outcome_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_EXP,
    ST_COOL,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic               command;
    logic signed [31:0] fitness;
    logic [15:0]        random_fraction;
  } cand_t;

  typedef struct packed {
    logic               accepted;
    logic [2:0]         outcome;
    logic signed [31:0] parent_fitness_out;
    logic signed [31:0] best_fitness_out;
    logic [31:0]        temperature_out;
    logic               done_res;
  } res_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] index;
    logic [31:0]            data;
  } cfg_t;

  // Q0.32 factor for exp step k: integer bits 1,2,4,8 first, then
  // exp(-2^-1) .. exp(-2^-16)
  function automatic logic [31:0] exp_step_const(input logic [4:0] k);
    logic [31:0] c;
    unique case (k)
      5'd0:    c = 32'd1580030169;
      5'd1:    c = 32'd581260615;
      5'd2:    c = 32'd78665070;
      5'd3:    c = 32'd1440801;
      5'd4:    c = 32'd2605029347;
      5'd5:    c = 32'd3344923893;
      5'd6:    c = 32'd3790295335;
      5'd7:    c = 32'd4034748382;
      5'd8:    c = 32'd4162825044;
      5'd9:    c = 32'd4228380000;
      5'd10:   c = 32'd4261543595;
      5'd11:   c = 32'd4278222805;
      5'd12:   c = 32'd4286586875;
      5'd13:   c = 32'd4290775039;
      5'd14:   c = 32'd4292870656;
      5'd15:   c = 32'd4293918848;
      5'd16:   c = 32'd4294443040;
      5'd17:   c = 32'd4294705160;
      5'd18:   c = 32'd4294836226;
      5'd19:   c = 32'd4294901760;
      default: c = 32'd0;
    endcase
    return c;
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

### rtl/aac_stream_if.sv
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one item of payload_t per handshake.
// ----------------------------------------------------------------------------
interface aac_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/annealing_acceptance_controller.sv
// ----------------------------------------------------------------------------
// Annealing acceptance controller
// Metropolis acceptance with geometric cooling over Q16.16 fitness items.
//
//   channel | dir | payload                  | accepted when
//   --------+-----+--------------------------+---------------------------
//   cand    | in  | aac_pkg::cand_t          | cand.valid && cand.ready
//   res     | out | aac_pkg::res_t           | res.valid && res.ready
//   cfg     | in  | aac_pkg::cfg_t (idx,data)| cfg.valid && cfg.ready
//
// A load and a candidate after done go from EVAL straight to WRITE; an equal
// or better candidate and a worse one with zero probability pass through COOL.
// A worse candidate with nonzero probability first runs 20 restoring-division
// passes and 20 multiply passes through the one shared 33x32 multiplier.
// cand.ready is high only while the sequencer is idle; a result waiting in
// the output register does not block the next item until it is finished.
// rst is synchronous; cfg is always ready.
// ----------------------------------------------------------------------------
module annealing_acceptance_controller (
  input logic   clk,
  input logic   rst,
  aac_stream_if.sink   cand,
  aac_stream_if.source res,
  aac_stream_if.sink   cfg
);

  // Configuration registers
  logic [31:0] initial_temperature;
  logic [15:0] cool_mult;
  logic [31:0] iteration_limit;
  logic [31:0] stall_limit;

  // Search state
  logic signed [31:0] parent_value;
  logic signed [31:0] best_value;
  logic [31:0]        current_temperature;
  logic [31:0]        stall_count;
  logic [31:0]        iteration_count;
  logic               finished;

  // Sequencer and working registers
  aac_pkg::state_t    state, state_next;
  aac_pkg::cand_t     item;
  aac_pkg::outcome_t  outcome;
  logic               accepted;
  logic               is_worse;
  logic [4:0]         step;
  logic [31:0]        rem;
  logic [aac_pkg::X_W-1:0] quot;
  logic [32:0]        prob;
  logic               res_valid;
  aac_pkg::res_t      res_data;

  // Datapath signals
  logic signed [32:0] delta_full;
  logic [35:0]        delta_sh;
  logic               prob_zero;
  logic [32:0]        rem_sh;
  logic               rem_geq;
  logic [4:0]         exp_idx;
  logic [32:0]        mul_a;
  logic [31:0]        mul_b;
  logic [64:0]        mul_p;
  logic               slot_free;
  logic               new_best;
  logic               take_worse;
  logic [31:0]        iter_next;
  logic [31:0]        stall_next;
  logic               eval_accepted;
  aac_pkg::outcome_t  eval_outcome;
  logic               eval_worse;

  // Handshakes
  assign cand.ready  = (state == aac_pkg::ST_IDLE);
  assign cfg.ready   = 1'b1;
  assign res.valid   = res_valid;
  assign res.payload = res_data;
  assign slot_free   = !res_valid || res.ready;

  // Compare and exponent argument range check
  assign delta_full = 33'(item.fitness) - 33'(parent_value);
  assign delta_sh   = {delta_full[31:0], 4'b0000};
  assign prob_zero  = (current_temperature == 32'd0) ||
                      (delta_sh >= {4'b0000, current_temperature});

  // Restoring division pass
  assign rem_sh  = {rem, 1'b0};
  assign rem_geq = rem_sh >= {1'b0, current_temperature};

  // Exponent bit order: integer bits low to high, then fraction high to low
  assign exp_idx = (step < 5'd4) ? 5'(step + 5'd16) : 5'(5'd19 - step);

  // Shared multiplier: exp product during ST_EXP, cooling otherwise
  always_comb begin
    if (state == aac_pkg::ST_EXP) begin
      mul_a = prob;
      mul_b = aac_pkg::exp_step_const(step);
    end else begin
      mul_a = {1'b0, current_temperature};
      mul_b = {16'd0, cool_mult};
    end
  end
  assign mul_p = 65'(mul_a) * 65'(mul_b);

  // Counter updates of a processed candidate
  assign new_best   = item.fitness < best_value;
  assign take_worse = is_worse && ({1'b0, item.random_fraction} < prob[32:16]);
  assign iter_next  = aac_pkg::sat_inc(iteration_count);
  assign stall_next = new_best ? 32'd0 : aac_pkg::sat_inc(stall_count);

  // Classify the item in flight
  always_comb begin
    eval_accepted = 1'b0;
    eval_outcome  = aac_pkg::OUT_IGNORED;
    eval_worse    = 1'b0;
    priority if (item.command == aac_pkg::CMD_LOAD) begin
      eval_accepted = 1'b1;
      eval_outcome  = aac_pkg::OUT_LOADED;
    end else if (finished) begin
      eval_outcome  = aac_pkg::OUT_IGNORED;
    end else if (item.fitness < parent_value) begin
      eval_accepted = 1'b1;
      eval_outcome  = aac_pkg::OUT_IMPROVED;
    end else if (item.fitness > parent_value) begin
      eval_worse    = 1'b1;
    end else begin
      eval_outcome  = aac_pkg::OUT_IGNORED;
    end
  end

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aac_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance the sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      aac_pkg::ST_IDLE: begin
        if (cand.valid) state_next = aac_pkg::ST_EVAL;
      end
      aac_pkg::ST_EVAL: begin
        priority if (item.command == aac_pkg::CMD_LOAD) begin
          state_next = aac_pkg::ST_WRITE;
        end else if (finished) begin
          state_next = aac_pkg::ST_WRITE;
        end else if (item.fitness > parent_value && !prob_zero) begin
          state_next = aac_pkg::ST_DIV;
        end else begin
          state_next = aac_pkg::ST_COOL;
        end
      end
      aac_pkg::ST_DIV: begin
        if (step == aac_pkg::STEP_LAST) state_next = aac_pkg::ST_EXP;
      end
      aac_pkg::ST_EXP: begin
        if (step == aac_pkg::STEP_LAST) state_next = aac_pkg::ST_COOL;
      end
      aac_pkg::ST_COOL: begin
        state_next = aac_pkg::ST_WRITE;
      end
      aac_pkg::ST_WRITE: begin
        if (slot_free) state_next = aac_pkg::ST_IDLE;
      end
      default: state_next = aac_pkg::ST_IDLE;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_temperature <= aac_pkg::INITIAL_TEMPERATURE_RST;
      cool_mult           <= aac_pkg::COOL_MULT_RST;
      iteration_limit     <= aac_pkg::ITERATION_LIMIT_RST;
      stall_limit         <= aac_pkg::STALL_LIMIT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.payload.index)
        aac_pkg::REG_INITIAL_TEMPERATURE: initial_temperature <= cfg.payload.data;
        aac_pkg::REG_COOL_MULT:           cool_mult           <= cfg.payload.data[15:0];
        aac_pkg::REG_ITERATION_LIMIT:     iteration_limit     <= cfg.payload.data;
        aac_pkg::REG_STALL_LIMIT:         stall_limit         <= cfg.payload.data;
        default: ;
      endcase
    end
  end

  // Search state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      parent_value        <= '0;
      best_value          <= '0;
      current_temperature <= aac_pkg::INITIAL_TEMPERATURE_RST;
      stall_count         <= '0;
      iteration_count     <= '0;
      finished            <= 1'b0;
    end else if (state == aac_pkg::ST_EVAL && item.command == aac_pkg::CMD_LOAD) begin
      parent_value        <= item.fitness;
      best_value          <= item.fitness;
      current_temperature <= initial_temperature;
      stall_count         <= '0;
      iteration_count     <= 32'd1;
      finished            <= (iteration_limit <= 32'd1);
    end else if (state == aac_pkg::ST_COOL) begin
      if (outcome == aac_pkg::OUT_IMPROVED || take_worse) parent_value <= item.fitness;
      if (new_best) best_value <= item.fitness;
      current_temperature <= mul_p[47:16];
      stall_count         <= stall_next;
      iteration_count     <= iter_next;
      finished            <= (stall_next > stall_limit) || (iter_next >= iteration_limit);
    end
  end

  // Working registers of the item in flight
  always_ff @(posedge clk) begin
    unique case (state)
      aac_pkg::ST_IDLE: begin
        item <= cand.payload;
      end
      aac_pkg::ST_EVAL: begin
        step     <= '0;
        rem      <= delta_sh[31:0];
        prob     <= prob_zero ? 33'd0 : {1'b1, 32'd0};
        is_worse <= eval_worse;
        accepted <= eval_accepted;
        outcome  <= eval_outcome;
      end
      aac_pkg::ST_DIV: begin
        rem  <= rem_geq ? 32'(rem_sh - {1'b0, current_temperature}) : rem_sh[31:0];
        quot <= {quot[aac_pkg::X_W-2:0], rem_geq};
        step <= (step == aac_pkg::STEP_LAST) ? 5'd0 : 5'(step + 5'd1);
      end
      aac_pkg::ST_EXP: begin
        if (quot[exp_idx]) prob <= mul_p[64:32];
        step <= 5'(step + 5'd1);
      end
      aac_pkg::ST_COOL: begin
        if (is_worse) begin
          accepted <= take_worse;
          outcome  <= take_worse ? aac_pkg::OUT_WORSE_ACCEPTED
                                 : aac_pkg::OUT_WORSE_REJECTED;
        end
      end
      aac_pkg::ST_WRITE: ;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == aac_pkg::ST_WRITE && slot_free) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == aac_pkg::ST_WRITE && slot_free) begin
      res_data.accepted           <= accepted;
      res_data.outcome            <= outcome;
      res_data.parent_fitness_out <= parent_value;
      res_data.best_fitness_out   <= best_value;
      res_data.temperature_out    <= current_temperature;
      res_data.done_res           <= finished;
    end
  end

  // Division remainder always stays below the temperature
  a_rem_below_temp: assert property (@(posedge clk) disable iff (rst)
    state == aac_pkg::ST_DIV |-> rem < current_temperature)
    else $error("division remainder not below temperature");

  // An accepted item is evaluated in the next cycle
  a_accept_to_eval: assert property (@(posedge clk) disable iff (rst)
    cand.valid && cand.ready |=> state == aac_pkg::ST_EVAL)
    else $error("accepted item not evaluated");

  // A candidate after done skips all arithmetic
  a_done_skips: assert property (@(posedge clk) disable iff (rst)
    state == aac_pkg::ST_EVAL && item.command == aac_pkg::CMD_EVALUATE && finished
    |=> state == aac_pkg::ST_WRITE)
    else $error("candidate after done not ignored");

  // The accepted flag agrees with the outcome code
  a_accept_outcome: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_data.accepted == (res_data.outcome == aac_pkg::OUT_LOADED ||
                                        res_data.outcome == aac_pkg::OUT_IMPROVED ||
                                        res_data.outcome == aac_pkg::OUT_WORSE_ACCEPTED))
    else $error("accepted flag disagrees with outcome");

  // The best fitness never exceeds the parent fitness
  a_best_le_parent: assert property (@(posedge clk) disable iff (rst)
    state == aac_pkg::ST_IDLE |-> best_value <= parent_value)
    else $error("best fitness above parent fitness");

endmodule
